// ----- rtl/core/elps_pkg.sv -----
// Shared types, constants and helper functions for the EOL-pair line splitter.
package elps_pkg;

    // Field widths
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 12;
    localparam int LENGTH_BITS = 12;
    localparam int LEN_MAX     = (1 << LENGTH_BITS) - 1;

    // Results one input byte can produce
    localparam int MAX_RES = 4;
    localparam int RES_IW  = $clog2(MAX_RES);
    localparam int RES_NW  = $clog2(MAX_RES + 1);

    // Command queue; depth must be a power of two so pointers wrap
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // End-of-line characters
    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;

    localparam logic [LEN_W-1:0] MAX_LINE_LEN_RST = 12'd255;

    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_LINE    = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_PART    = 2'd3
    } kind_t;

    // One result beat
    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
    } res_t;

    // All results caused by one input byte; cnt_m1 is count minus one
    typedef struct packed {
        logic [RES_IW-1:0]      cnt_m1;
        res_t [MAX_RES-1:0]     res;
    } cmd_t;

    // Limit of 0 acts as 1; limits beyond the counter saturate
    function automatic logic [LENGTH_BITS-1:0] eff_limit(input logic [LEN_W-1:0] cfg);
        logic [16:0] m;
        m = 17'(cfg);
        if (m == 17'd0)
            m = 17'd1;
        if (m > 17'(LEN_MAX))
            m = 17'(LEN_MAX);
        return m[LENGTH_BITS-1:0];
    endfunction

    // Counter value to the line_len field width
    function automatic logic [LEN_W-1:0] to_len(input logic [LENGTH_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[LEN_W-1:0];
    endfunction

endpackage

// ----- rtl/core/elps_in_if.sv -----
// Input channel: one received byte per beat.
interface elps_in_if import elps_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// ----- rtl/core/elps_out_if.sv -----
// Output channel: one framing result per beat.
interface elps_out_if import elps_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0]  line_len;
    logic              last;

    modport source (output valid, output kind, output char_out, output line_len,
                    output last, input ready);
    modport sink   (input valid, input kind, input char_out, input line_len,
                    input last, output ready);
endinterface

// ----- rtl/core/elps_front.sv -----
// Front end: accepts bytes, tracks line state and builds the result list per byte.
module elps_front import elps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    elps_in_if.sink          in_ch,
    input  logic [LEN_W-1:0] max_line_len,
    input  logic             q_full,
    output logic             q_push,
    output cmd_t             q_data
);

    logic                   pend_reg, pend_next;
    logic [CHAR_W-1:0]      held_reg, held_next;
    logic [LENGTH_BITS-1:0] chunk_reg, chunk_next;

    logic                   accept;
    logic                   is_eol;
    logic [LENGTH_BITS-1:0] lim;
    logic [LENGTH_BITS-1:0] cnt;
    logic [RES_NW-1:0]      n;
    logic [1:0]             step_v;
    logic [CHAR_W-1:0]      step_ch [2];

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_eol      = (in_ch.byte_in == CH_CR) || (in_ch.byte_in == CH_LF);
    assign lim         = eff_limit(max_line_len);

    // Classify the byte and fill result slots in order
    always_comb
    begin
        pend_next  = pend_reg;
        held_next  = held_reg;
        chunk_next = chunk_reg;
        cnt        = chunk_reg;
        n          = '0;
        q_data     = '0;
        step_v     = 2'b00;
        step_ch[0] = held_reg;
        step_ch[1] = in_ch.byte_in;

        if (accept)
        begin
            if (is_eol)
            begin
                if (pend_reg)
                begin
                    // EOL pair closes the line
                    if (cnt == '0)
                        q_data.res[0].kind = KIND_EMPTY;
                    else
                    begin
                        q_data.res[0].kind = KIND_LINE;
                        q_data.res[0].len  = to_len(cnt);
                    end
                    n         = RES_NW'(1);
                    cnt       = '0;
                    pend_next = 1'b0;
                    held_next = '0;
                end
                else
                begin
                    pend_next = 1'b1;
                    held_next = in_ch.byte_in;
                end
            end
            else
            begin
                // held EOL first, then the byte itself
                step_v    = {1'b1, pend_reg};
                pend_next = 1'b0;
                held_next = '0;
            end

            for (int i = 0; i < 2; i++)
            begin
                if (step_v[i])
                begin
                    if (cnt >= lim)
                    begin
                        q_data.res[n[RES_IW-1:0]].kind = KIND_PART;
                        q_data.res[n[RES_IW-1:0]].len  = to_len(cnt);
                        n   = n + 1'b1;
                        cnt = '0;
                    end
                    q_data.res[n[RES_IW-1:0]].kind = KIND_CONTENT;
                    q_data.res[n[RES_IW-1:0]].ch   = step_ch[i];
                    n   = n + 1'b1;
                    cnt = cnt + 1'b1;
                end
            end
            chunk_next = cnt;
        end

        q_data.cnt_m1 = RES_IW'(n - 1'b1);
    end

    assign q_push = accept && (n != '0);

    // Line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            held_reg  <= '0;
            chunk_reg <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            held_reg  <= held_next;
            chunk_reg <= chunk_next;
        end
    end

`ifndef ASSERT_OFF
    // A lone EOL produces nothing
    a_lone_eol_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_eol && !pend_reg) |-> !q_push)
        else $error("lone EOL pushed a command");

    // Any normal byte always produces a command
    a_byte_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_eol) |-> q_push)
        else $error("normal byte produced no result");
`endif

endmodule

// ----- rtl/core/elps_cmd_fifo.sv -----
// Short command queue between front and back ends.
module elps_cmd_fifo import elps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t pop_data,
    output logic full,
    output logic empty
);

    cmd_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;

    assign full     = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/core/elps_back.sv -----
// Back end: walks each queued command and sends its results one beat at a time.
module elps_back import elps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_data,
    output logic       q_pop,
    elps_out_if.source out_ch
);

    logic              out_valid_reg;
    logic [RES_IW-1:0] idx_reg;
    logic [1:0]        kind_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              last_reg;

    logic              load;
    logic              take;
    logic              is_last;
    res_t              cur;

    assign load    = !out_valid_reg || out_ch.ready;
    assign take    = load && !q_empty;
    assign cur     = q_data.res[idx_reg];
    assign is_last = (idx_reg == q_data.cnt_m1);
    assign q_pop   = take && is_last;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.kind     = kind_reg;
    assign out_ch.char_out = char_reg;
    assign out_ch.line_len = len_reg;
    assign out_ch.last     = last_reg;

    // Beat control and slot index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= is_last ? '0 : idx_reg + 1'b1;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= cur.kind;
            char_reg <= cur.ch;
            len_reg  <= cur.len;
            last_reg <= is_last;
        end
    end

`ifndef ASSERT_OFF
    // Slot index returns to zero once a command is fully sent
    a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (idx_reg == '0))
        else $error("slot index not reset after command");
`endif

endmodule

// ----- rtl/core/eol_pair_line_splitter_top.sv -----
// Top level of the EOL-pair line splitter.
// Splits a received byte stream into lines: two EOL characters (CR or LF, any mix) end a
// line, a lone one is held and turns into content if a normal byte follows. Each byte
// yields zero to four result beats (content bytes, line end, empty line, chunk end).
// The front end takes one byte per cycle while the two-entry command queue has room;
// the back end sends one result beat per cycle from its output register while the
// output is ready, and the back end's result walk sets the sustained rate. The user
// must write max_line_len only while the block is idle; the block itself does not
// enforce it. No clearing pass follows reset.
module eol_pair_line_splitter_top import elps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    elps_in_if.sink          in_ch,
    elps_out_if.source       out_ch
);

    logic [LEN_W-1:0] max_line_len_reg;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    cmd_t             q_wdata;
    cmd_t             q_rdata;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_line_len_reg <= MAX_LINE_LEN_RST;
        else if (cfg_wr_en)
            max_line_len_reg <= cfg_wr_data;
    end

    elps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .max_line_len (max_line_len_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_wdata)
    );

    elps_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    elps_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule
